// ===== rtl/core/spq_pkg.sv =====
// Shared types and codes for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int TagW   = 16;
  localparam int PrioW  = 16;
  localparam int CountW = 6;

  // Operation kind carried on s_tuser
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Result status carried on m_tuser
  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_EMPTY    = 2'd2
  } status_t;

  // One queue slot held by a cell
  typedef struct packed {
    logic             occ;
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
  } entry_t;

  // Operation broadcast to every cell
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [TagW-1:0]  tag;
    logic [PrioW-1:0] prio;
  } cell_op_t;

endpackage
`default_nettype wire

// ===== rtl/core/sorted_priority_queue.sv =====
// Top level: sorted priority queue built as a chain of compare-and-shift cells.
// Usage:
//   Slave channel (s_*) carries operations: s_tuser selects insert or remove,
//   s_tdata carries the tag and priority of an insert (ignored on remove).
//   Master channel (m_*) returns one result per operation: status on m_tuser,
//   removed tag/priority and the live count on m_tdata.
//   Every cell compares its entry with the incoming priority in parallel and
//   shifts toward its neighbor in the same cycle; the result appears on m_*
//   in the cycle after the transfer, and a new operation is taken every cycle
//   while the receiver does not stall. The per-cell compare and the
//   neighbor mux set the cycle time; DEPTH sets the number of cells.
//   Equal priorities leave first in, first out. An insert into a full queue
//   reports overflow; a remove from an empty queue reports empty; neither
//   changes the contents.
//   Reset empties the queue and drops any pending result. While the receiver
//   stalls, the result register holds and s_tready stays low.
`default_nettype none
module sorted_priority_queue #(
  parameter int DEPTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,  // [15:0] tag, [31:16] prio
  input  wire logic        s_tuser,  // [0] kind
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,  // [15:0] out_tag, [31:16] out_prio,
                                     // [37:32] live_count, [39:38] zero
  output logic [1:0]       m_tuser   // [1:0] status
);
  import spq_pkg::*;

  localparam int HeldW = $clog2(DEPTH + 1);

  entry_t     cell_q [DEPTH];
  logic       cell_gt [DEPTH];
  cell_op_t   op;
  logic       fire;
  logic       full;
  logic       empty;
  logic [HeldW-1:0] held;
  logic [HeldW-1:0] held_next;
  logic [HeldW+CountW-1:0] held_wide;
  status_t    status_next;
  logic [TagW-1:0]  tag_next;
  logic [PrioW-1:0] prio_next;

  assign s_tready = !m_tvalid || m_tready;
  assign fire     = s_tvalid && s_tready;
  assign full     = cell_q[DEPTH-1].occ;
  assign empty    = !cell_q[0].occ;

  // Broadcast operation to the chain
  always_comb begin
    op.ins  = fire && (s_tuser == KIND_INSERT) && !full;
    op.rem  = fire && (s_tuser == KIND_REMOVE) && !empty;
    op.tag  = s_tdata[TagW-1:0];
    op.prio = s_tdata[TagW+PrioW-1:TagW];
  end

  // Chain of cells
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    entry_t left_e;
    logic   left_g;
    entry_t right_e;

    if (i == 0) begin : g_head
      assign left_e = '{occ: 1'b1, tag: '0, prio: '0};
      assign left_g = 1'b0;
    end else begin : g_body
      assign left_e = cell_q[i-1];
      assign left_g = cell_gt[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign right_e = '0;
    end else begin : g_mid
      assign right_e = cell_q[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .op          (op),
      .left_entry  (left_e),
      .left_gt     (left_g),
      .right_entry (right_e),
      .entry       (cell_q[i]),
      .gt          (cell_gt[i])
    );
  end

  // Result fields and count update
  always_comb begin
    status_next = ST_DONE;
    tag_next    = '0;
    prio_next   = '0;
    held_next   = held;
    if (s_tuser == KIND_INSERT) begin
      if (full) begin
        status_next = ST_OVERFLOW;
      end else begin
        held_next = held + HeldW'(1);
      end
    end else begin
      if (empty) begin
        status_next = ST_EMPTY;
      end else begin
        tag_next  = cell_q[0].tag;
        prio_next = cell_q[0].prio;
        held_next = held - HeldW'(1);
      end
    end
  end

  assign held_wide = {{CountW{1'b0}}, held_next};

  // Live count
  always_ff @(posedge clk) begin
    if (rst) begin
      held <= '0;
    end else if (fire) begin
      held <= held_next;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      m_tdata <= {2'b00, held_wide[CountW-1:0], prio_next, tag_next};
      m_tuser <= status_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/spq_cell.sv =====
// One slot of the sorted chain: compare against the new entry and shift.
`default_nettype none
module spq_cell (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire spq_pkg::cell_op_t op,
  input  wire spq_pkg::entry_t  left_entry,
  input  wire logic             left_gt,
  input  wire spq_pkg::entry_t  right_entry,
  output spq_pkg::entry_t       entry,
  output logic                  gt
);
  import spq_pkg::*;

  entry_t entry_next;

  // Held entry orders after the new one
  assign gt = entry.occ && (entry.prio > op.prio);

  // Shift left on remove; on insert shift right or take the new entry
  always_comb begin
    entry_next = entry;
    if (op.rem) begin
      entry_next = right_entry;
    end else if (op.ins) begin
      if (left_gt) begin
        entry_next = left_entry;
      end else if (left_entry.occ && (!entry.occ || gt)) begin
        entry_next.occ  = 1'b1;
        entry_next.tag  = op.tag;
        entry_next.prio = op.prio;
      end
    end
  end

  // Occupancy is control, payload needs no reset
  always_ff @(posedge clk) begin
    entry.tag  <= entry_next.tag;
    entry.prio <= entry_next.prio;
    if (rst) begin
      entry.occ <= 1'b0;
    end else begin
      entry.occ <= entry_next.occ;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/spq_checker.sv =====
// Port-level checks for the sorted priority queue, bound to the top level.
`default_nettype none
module spq_checker #(
  parameter int DEPTH = 32
) (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic [31:0] s_tdata,
  input wire logic        s_tuser,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [1:0]  m_tuser
);
  import spq_pkg::*;

  localparam logic [CountW-1:0] FullCount = CountW'(DEPTH);

  // Empty status only when nothing is held
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_EMPTY) |-> (m_tdata[37:32] == '0))
    else $error("empty status with nonzero live count");

  // Overflow only when the queue is at capacity
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == ST_OVERFLOW) |-> (m_tdata[37:32] == FullCount))
    else $error("overflow status below capacity");

  // Refused operations return no entry
  a_refused_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_DONE) |-> (m_tdata[31:0] == '0))
    else $error("refused operation returned an entry");

  // Stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
    else $error("result changed while stalled");

endmodule

bind sorted_priority_queue spq_checker #(.DEPTH(DEPTH)) u_spq_checker (.*);
`default_nettype wire

// ===== tb/spq_checker.sv =====
// Scoreboard for the sorted priority queue: predicts each result and compares it.
`timescale 1ns / 100ps
module spq_scoreboard #(
  parameter int DEPTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [31:0] s_tdata,   // [15:0] tag, [31:16] prio
  input  logic        s_tuser,   // [0] kind
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [39:0] m_tdata,   // [15:0] out_tag, [31:16] out_prio, [37:32] live_count
  input  logic [1:0]  m_tuser,   // [1:0] status
  output int          fail_count,
  output int          pending
);
  import spq_pkg::*;

  typedef struct packed {
    status_t           status;
    logic [TagW-1:0]   tag;
    logic [PrioW-1:0]  prio;
    logic [CountW-1:0] count;
  } outcome_t;

  // Shadow copy of the queue, ascending priority in slots 0 .. held-1
  logic [PrioW-1:0] slot_prio [DEPTH];
  logic [TagW-1:0]  slot_tag  [DEPTH];
  int               held;

  outcome_t outcome_fifo [$];
  int       mismatches = 0;

  initial begin
    fail_count = 0;
    pending    = 0;
    held       = 0;
  end

  // Apply one operation to the shadow queue and return the result it yields
  function automatic outcome_t apply_queue_op(logic kind, logic [TagW-1:0] tag,
                                              logic [PrioW-1:0] prio);
    outcome_t res;
    int pos;
    res.status = ST_DONE;
    res.tag    = '0;
    res.prio   = '0;
    if (kind == KIND_INSERT) begin
      if (held >= DEPTH) begin
        res.status = ST_OVERFLOW;
      end else begin
        // land behind every entry with an equal or smaller priority
        pos = held;
        while (pos > 0 && slot_prio[pos-1] > prio) begin
          slot_prio[pos] = slot_prio[pos-1];
          slot_tag[pos]  = slot_tag[pos-1];
          pos--;
        end
        slot_prio[pos] = prio;
        slot_tag[pos]  = tag;
        held++;
      end
    end else begin
      if (held == 0) begin
        res.status = ST_EMPTY;
      end else begin
        res.tag  = slot_tag[0];
        res.prio = slot_prio[0];
        for (int i = 1; i < held; i++) begin
          slot_prio[i-1] = slot_prio[i];
          slot_tag[i-1]  = slot_tag[i];
        end
        held--;
      end
    end
    res.count = held[CountW-1:0];
    return res;
  endfunction

  function automatic void check_field(string label, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, label, want, want, got, got);
      mismatches++;
    end
  endfunction

  // Results are checked before the same-edge operation is predicted: the
  // block answers in the cycle after the transfer at the earliest.
  always @(posedge clk) begin
    outcome_t want;
    if (rst) begin
      held = 0;
      outcome_fifo.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (outcome_fifo.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual status %0d tag 0x%0h",
                   $time, m_tuser, m_tdata[15:0]);
          mismatches++;
        end else begin
          want = outcome_fifo.pop_front();
          check_field("status",     want.status, m_tuser);
          check_field("out_tag",    want.tag,    m_tdata[15:0]);
          check_field("out_prio",   want.prio,   m_tdata[31:16]);
          check_field("live_count", want.count,  m_tdata[37:32]);
        end
      end
      if (s_tvalid && s_tready)
        outcome_fifo.push_back(apply_queue_op(s_tuser, s_tdata[15:0], s_tdata[31:16]));
    end
    pending    <= outcome_fifo.size();
    fail_count <= mismatches;
  end

endmodule

// ===== tb/tb_sorted_priority_queue.sv =====
// Testbench top for the sorted priority queue: stimulus, reset, watchdog and verdict.
`timescale 1ns / 100ps
module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int DEPTH      = 32;
  localparam int STALL_LIMIT = 2000;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata  = '0;  // [15:0] tag, [31:16] prio
  logic        s_tuser  = KIND_INSERT;  // [0] kind
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;  // [15:0] out_tag, [31:16] out_prio, [37:32] live_count
  logic [1:0]  m_tuser;  // [1:0] status

  int fail_count;
  int pending;
  int send_idle_pct = 29;
  int recv_idle_pct = 46;
  int quiet_cycles  = 0;

  always #10 clk = ~clk;

  sorted_priority_queue #(.DEPTH(DEPTH)) u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  spq_scoreboard #(.DEPTH(DEPTH)) u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .fail_count(fail_count), .pending(pending)
  );

  // Random backpressure on the result side
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Watchdog: too long without any transfer ends the run
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("tb_sorted_priority_queue: FAIL");
        $finish;
      end
    end
  end

  // One operation, with random idle cycles ahead of it; valid stays up after
  // the transfer so back-to-back operations need no gap.
  task automatic send_op(input logic kind, input logic [TagW-1:0] tag,
                         input logic [PrioW-1:0] prio);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {prio, tag};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
  endtask

  // Stop sending and wait until every result has come back
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Mix of dense ties, extremes and full-range priorities
  function automatic logic [PrioW-1:0] pick_prio();
    case ($urandom_range(3))
      0:       return PrioW'($urandom_range(7));
      1: begin
        case ($urandom_range(3))
          0:       return 16'h0000;
          1:       return 16'h0001;
          2:       return 16'hFFFE;
          default: return 16'hFFFF;
        endcase
      end
      default: return PrioW'($urandom);
    endcase
  endfunction

  // Bursts that lean toward filling, draining or holding the queue level
  task automatic run_random(input int count);
    int left;
    int burst;
    int ins_pct;
    left = count;
    while (left > 0) begin
      burst = $urandom_range(60, 10);
      case ($urandom_range(2))
        0:       ins_pct = 85;
        1:       ins_pct = 15;
        default: ins_pct = 55;
      endcase
      for (int i = 0; i < burst && left > 0; i++) begin
        send_op(($urandom_range(99) < ins_pct) ? KIND_INSERT : KIND_REMOVE,
                TagW'($urandom), pick_prio());
        left--;
      end
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty remove, field extremes, FIFO order among equal priorities
    send_op(KIND_REMOVE, 16'hFFFF, 16'hFFFF);
    send_op(KIND_INSERT, 16'h0000, 16'hFFFF);
    send_op(KIND_INSERT, 16'hFFFF, 16'h0000);
    send_op(KIND_INSERT, 16'h0001, 16'h0005);
    send_op(KIND_INSERT, 16'h0002, 16'h0005);
    send_op(KIND_INSERT, 16'h0003, 16'h0005);
    send_op(KIND_INSERT, 16'h0004, 16'h0000);
    send_op(KIND_INSERT, 16'hAAAA, 16'h8000);
    send_op(KIND_INSERT, 16'h5555, 16'h7FFF);
    repeat (8) send_op(KIND_REMOVE, 16'h0000, 16'h0000);
    send_op(KIND_REMOVE, 16'h0000, 16'h0000);

    // Fill past capacity to hit overflow, then drain past empty
    repeat (DEPTH + 2) send_op(KIND_INSERT, TagW'($urandom), pick_prio());
    repeat (DEPTH + 2) send_op(KIND_REMOVE, TagW'($urandom), PrioW'($urandom));

    run_random(360);
    drain_results();

    send_idle_pct <= 46;
    recv_idle_pct <= 29;
    run_random(360);
    drain_results();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    run_random(360);
    drain_results();
    repeat (5) @(posedge clk);

    if (fail_count == 0 && pending == 0)
      $display("tb_sorted_priority_queue: PASS");
    else
      $display("tb_sorted_priority_queue: FAIL");
    $finish;
  end

endmodule
